// ===== rtl/core/sha256_message_hasher_unit_assert.svh =====
// Assertion macros shared by the SHA-256 hasher RTL.
// Assertions compile to nothing when SYNTHESIS is defined.
`ifndef SHA256_MESSAGE_HASHER_UNIT_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SHAMH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SHAMH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SHAMH_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SHAMH_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/core/shamh_pkg.sv =====
// Types, constants and tables of the SHA-256 message hasher.
// No dependencies.
package shamh_pkg;

   typedef logic [31:0] word_type;
   typedef word_type hash_type [8];

   localparam logic       KIND_DATA   = 1'b0;
   localparam logic       KIND_FINISH = 1'b1;
   localparam logic [7:0] PAD_MARKER  = 8'h80;
   localparam logic [5:0] LENGTH_POS  = 6'd56;
   localparam logic [5:0] LAST_BYTE   = 6'd63;
   localparam logic [5:0] LAST_ROUND  = 6'd63;
   localparam logic [2:0] LAST_WORD   = 3'd7;

   localparam hash_type INITIAL_HASH = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        last_word;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_HASH_ADD,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/core/shamh_chan_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on shamh_pkg.
interface shamh_req_if import shamh_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface shamh_rsp_if import shamh_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/shamh_round.sv =====
// One SHA-256 compression round and the matching message schedule step.
// Depends on shamh_pkg.
module shamh_round import shamh_pkg::*; (
   input  hash_type work_cur,
   input  word_type w_t,
   input  word_type w_1,
   input  word_type w_9,
   input  word_type w_14,
   input  word_type k_t,
   output hash_type work_nxt,
   output word_type w_new
);

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   word_type t1;
   word_type t2;
   word_type choose;
   word_type majority;

   always_comb begin
      choose   = (work_cur[4] & work_cur[5]) ^ (~work_cur[4] & work_cur[6]);
      majority = (work_cur[0] & work_cur[1]) ^ (work_cur[0] & work_cur[2]) ^
                 (work_cur[1] & work_cur[2]);
      t1 = work_cur[7] + big_sigma1(work_cur[4]) + choose + k_t + w_t;
      t2 = big_sigma0(work_cur[0]) + majority;
      work_nxt[7] = work_cur[6];
      work_nxt[6] = work_cur[5];
      work_nxt[5] = work_cur[4];
      work_nxt[4] = work_cur[3] + t1;
      work_nxt[3] = work_cur[2];
      work_nxt[2] = work_cur[1];
      work_nxt[1] = work_cur[0];
      work_nxt[0] = t1 + t2;
      w_new = small_sigma1(w_14) + w_9 + small_sigma0(w_1) + w_t;
   end

endmodule

// ===== rtl/core/sha256_message_hasher_unit.sv =====
// SHA-256 message hasher top level: byte intake, padding sequencer and round loop.
// Depends on shamh_pkg, shamh_chan_if, shamh_round and the assertion header.
//
//   Channel   Direction   Payload                      Role
//   req_if    in          kind, data_byte              message bytes or finish
//   rsp_if    out         digest_word, last_word       eight digest words
//
// Data bytes are taken one per cycle while the hasher is idle; the 64th byte of a
// block starts the round loop on the single shared round unit, then the hash update.
// A finish transaction shifts in padding one byte per cycle and runs one or
// two compressions, then offers eight response transactions in order.
// Reset is synchronous and active high; requests are refused while padding is being
// shifted in, a block is being compressed or a digest is being delivered.
`include "sha256_message_hasher_unit_assert.svh"

module sha256_message_hasher_unit import shamh_pkg::*; (
   input logic         clock,
   input logic         reset,
   shamh_req_if.sink   req_if,
   shamh_rsp_if.source rsp_if
);

   state_type    state_ff, state_in;
   logic [511:0] block_ff, block_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  msg_bits_ff, msg_bits_in;
   hash_type     hash_ff, hash_in;
   hash_type     work_ff, work_in;
   logic [5:0]   round_ff, round_in;
   logic         finishing_ff, finishing_in;
   logic         marker_done_ff, marker_done_in;
   logic         len_blk_ff, len_blk_in;
   logic [2:0]   word_idx_ff, word_idx_in;

   logic         req_fire;
   logic         rsp_fire;
   logic         last_fire;
   logic         shift_en;
   logic [7:0]   shift_byte;
   logic [7:0]   len_byte;
   logic [7:0]   pad_byte;
   hash_type     work_nxt;
   word_type     w_new;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = (state_ff == ST_EMIT);
   assign rsp_if.payload.digest_word = hash_ff[word_idx_ff];
   assign rsp_if.payload.last_word   = (word_idx_ff == LAST_WORD);

   assign req_fire  = req_if.valid && req_if.ready;
   assign rsp_fire  = rsp_if.valid && rsp_if.ready;
   assign last_fire = rsp_fire && (word_idx_ff == LAST_WORD);

   shamh_round u_round (
      .work_cur (work_ff),
      .w_t      (block_ff[511 -: 32]),
      .w_1      (block_ff[479 -: 32]),
      .w_9      (block_ff[223 -: 32]),
      .w_14     (block_ff[63 -: 32]),
      .k_t      (ROUND_K[round_ff]),
      .work_nxt (work_nxt),
      .w_new    (w_new)
   );

   always_comb begin
      len_byte = msg_bits_ff[{~fill_ff[2:0], 3'b000} +: 8];
      if (!marker_done_ff) begin
         pad_byte = PAD_MARKER;
      end else if (len_blk_ff && (fill_ff >= LENGTH_POS)) begin
         pad_byte = len_byte;
      end else begin
         pad_byte = 8'h00;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.payload.kind == KIND_FINISH) begin
                  state_in = ST_PAD;
               end else if (fill_ff == LAST_BYTE) begin
                  state_in = ST_ROUND;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff == LAST_BYTE) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = ST_HASH_ADD;
            end
         end
         ST_HASH_ADD: begin
            if (finishing_ff && len_blk_ff) begin
               state_in = ST_EMIT;
            end else if (finishing_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (last_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      shift_en       = 1'b0;
      shift_byte     = pad_byte;
      block_in       = block_ff;
      fill_in        = fill_ff;
      msg_bits_in    = msg_bits_ff;
      hash_in        = hash_ff;
      work_in        = work_ff;
      round_in       = '0;
      finishing_in   = finishing_ff;
      marker_done_in = marker_done_ff;
      len_blk_in     = len_blk_ff;
      word_idx_in    = word_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            work_in = hash_ff;
            if (req_fire) begin
               if (req_if.payload.kind == KIND_FINISH) begin
                  finishing_in   = 1'b1;
                  marker_done_in = 1'b0;
                  len_blk_in     = 1'b0;
               end else begin
                  shift_en    = 1'b1;
                  shift_byte  = req_if.payload.data_byte;
                  msg_bits_in = msg_bits_ff + 64'd8;
               end
            end
         end
         ST_PAD: begin
            work_in        = hash_ff;
            shift_en       = 1'b1;
            marker_done_in = 1'b1;
            if (!marker_done_ff) begin
               len_blk_in = (fill_ff < LENGTH_POS);
            end
         end
         ST_ROUND: begin
            work_in  = work_nxt;
            round_in = round_ff + 6'd1;
            block_in = {block_ff[479:0], w_new};
         end
         ST_HASH_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
            if (finishing_ff) begin
               len_blk_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               word_idx_in = word_idx_ff + 3'd1;
            end
            if (last_fire) begin
               hash_in      = INITIAL_HASH;
               msg_bits_in  = '0;
               finishing_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
      if (shift_en) begin
         block_in = {block_ff[503:0], shift_byte};
         fill_in  = fill_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fill_ff        <= '0;
         msg_bits_ff    <= '0;
         hash_ff        <= INITIAL_HASH;
         round_ff       <= '0;
         finishing_ff   <= 1'b0;
         marker_done_ff <= 1'b0;
         len_blk_ff     <= 1'b0;
         word_idx_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         msg_bits_ff    <= msg_bits_in;
         hash_ff        <= hash_in;
         round_ff       <= round_in;
         finishing_ff   <= finishing_in;
         marker_done_ff <= marker_done_in;
         len_blk_ff     <= len_blk_in;
         word_idx_ff    <= word_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      work_ff  <= work_in;
   end

   `SHAMH_ASSERT_IMP(a_one_side_open, clock, reset, req_if.ready, !rsp_if.valid, "request and response sides open together")
   `SHAMH_ASSERT_IMP(a_round_aligned, clock, reset, state_ff == ST_ROUND, fill_ff == '0, "compression started on a partial block")
   `SHAMH_ASSERT_NXT(a_bit_count, clock, reset, req_fire && (req_if.payload.kind == KIND_DATA), msg_bits_ff == $past(msg_bits_ff) + 64'd8, "bit count did not advance by one byte")
   `SHAMH_ASSERT_NXT(a_rounds_end, clock, reset, (state_ff == ST_ROUND) && (round_ff == LAST_ROUND), state_ff == ST_HASH_ADD, "round loop did not end after the last round")
   `SHAMH_ASSERT_NXT(a_restart, clock, reset, last_fire, (msg_bits_ff == '0) && (hash_ff[0] == INITIAL_HASH[0]) && (state_ff == ST_IDLE), "hasher did not restart after the digest")

endmodule

// ===== dv/sha256_message_hasher_unit_tb.sv =====
// Self-checking testbench for sha256_message_hasher_unit: byte messages of
// boundary and random lengths, each digest checked against an in-bench SHA-256.
// Depends on shamh_pkg, shamh_chan_if and the hasher RTL.
module sha256_message_hasher_unit_tb;
   import shamh_pkg::*;

   class digest_scoreboard;
      word_type        hash_state [8];
      logic [63:0]     bit_count;
      logic [7:0]      block_bytes [64];
      int unsigned     fill;
      rsp_payload_type expected_digest_words [$];
      int unsigned     error_count;

      function new();
         foreach (block_bytes[i]) block_bytes[i] = 8'h00;
         error_count = 0;
         restart();
      endfunction

      function void restart();
         foreach (hash_state[i]) hash_state[i] = INITIAL_HASH[i];
         bit_count = 64'd0;
         fill = 0;
      endfunction

      function word_type rotr(word_type x, int unsigned n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress();
         word_type w [64];
         word_type v [8];
         word_type s0, s1, t1, t2;
         for (int i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
         end
         for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
         end
         foreach (v[i]) v[i] = hash_state[i];
         for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
         end
         foreach (hash_state[i]) hash_state[i] += v[i];
      endfunction

      function void note_request(req_payload_type item);
         int unsigned     pos;
         rsp_payload_type entry;
         if (item.kind == KIND_DATA) begin
            block_bytes[fill] = item.data_byte;
            bit_count += 64'd8;
            fill++;
            if (fill == 64) begin
               compress();
               fill = 0;
            end
         end else begin
            pos = fill;
            block_bytes[pos] = PAD_MARKER;
            pos++;
            if (pos > LENGTH_POS) begin
               for (int j = pos; j < 64; j++) block_bytes[j] = 8'h00;
               compress();
               pos = 0;
            end
            for (int j = pos; j < LENGTH_POS; j++) block_bytes[j] = 8'h00;
            for (int j = 0; j < 8; j++) block_bytes[LENGTH_POS + j] = bit_count[63 - 8*j -: 8];
            compress();
            for (int j = 0; j < 8; j++) begin
               entry.digest_word = hash_state[j];
               entry.last_word   = (j == LAST_WORD);
               expected_digest_words = {expected_digest_words, entry};
            end
            restart();
         end
      endfunction

      function void check_digest_word(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_digest_words.size() == 0) begin
            $display("%0t: unexpected digest word: expected none, actual %h last %b",
                     $time, got.digest_word, got.last_word);
            error_count++;
            return;
         end
         want = expected_digest_words.pop_front();
         if (got.digest_word !== want.digest_word) begin
            $display("%0t: digest_word mismatch: expected %h, actual %h",
                     $time, want.digest_word, got.digest_word);
            error_count++;
         end
         if (got.last_word !== want.last_word) begin
            $display("%0t: last_word mismatch: expected %b, actual %b",
                     $time, want.last_word, got.last_word);
            error_count++;
         end
      endfunction

      function int unsigned pending();
         return expected_digest_words.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   shamh_req_if req_if();
   shamh_rsp_if rsp_if();

   digest_scoreboard digest_board = new();

   int unsigned items_sent = 0;
   int unsigned messages_done = 0;
   bit          random_phase = 1'b0;
   bit          quiet_tail = 1'b0;
   bit          long_hold_done = 1'b0;

   sha256_message_hasher_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("sha256_message_hasher_unit test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         digest_board.check_digest_word(rsp_if.payload);
      end
   end

   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (random_phase && !long_hold_done && digest_board.pending() != 0) begin
            // Hold off long enough that a digest backs up and the block stops taking bytes.
            long_hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   task automatic send_item(input logic kind, input logic [7:0] value);
      req_if.valid <= 1'b1;
      req_if.payload <= '{kind: kind, data_byte: value};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      digest_board.note_request(req_if.payload);
      items_sent++;
      if (items_sent >= 200) quiet_tail = 1'b1;
   endtask

   task automatic idle_sender(input int unsigned cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_idle();
      if (!quiet_tail && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 19));
   endtask

   task automatic send_message(input int unsigned length);
      for (int unsigned i = 0; i < length; i++) begin
         maybe_idle();
         send_item(KIND_DATA, 8'($urandom_range(0, 255)));
      end
      maybe_idle();
      send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
      messages_done++;
   endtask

   function automatic int unsigned pick_length();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, 10);
         5, 6, 7: begin
            case ($urandom_range(0, 3))
               0: return 55;
               1: return 56;
               2: return 63;
               default: return 64;
            endcase
         end
         8: begin
            case ($urandom_range(0, 3))
               0: return 57;
               1: return 65;
               2: return 119;
               default: return 120;
            endcase
         end
         default: return $urandom_range(0, 130);
      endcase
   endfunction

   initial begin
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty message, with a data byte on the finish that must be ignored.
      send_item(KIND_FINISH, 8'ha5);
      send_item(KIND_DATA, 8'h61);
      send_item(KIND_DATA, 8'h62);
      send_item(KIND_DATA, 8'h63);
      send_item(KIND_FINISH, 8'h00);
      send_item(KIND_DATA, 8'h00);
      send_item(KIND_DATA, 8'hff);
      idle_sender(3);
      send_item(KIND_DATA, 8'h80);
      send_item(KIND_DATA, 8'h7f);
      send_item(KIND_FINISH, 8'hff);
      // Back-to-back finishes check that the state restarts after a digest.
      send_item(KIND_FINISH, 8'h5a);
      send_item(KIND_DATA, 8'hff);
      send_item(KIND_FINISH, 8'h3c);
      messages_done = 0;

      idle_sender(1);
      while (digest_board.pending() != 0) @(posedge clock);

      random_phase = 1'b1;
      while (items_sent < 250 || messages_done < 6) begin
         send_message(pick_length());
      end
      req_if.valid <= 1'b0;

      while (digest_board.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (digest_board.error_count == 0 && digest_board.pending() == 0) begin
         $display("sha256_message_hasher_unit test passed");
      end else begin
         $display("sha256_message_hasher_unit test failed");
      end
      $finish;
   end
endmodule
